FILE: rtl/hmbs_pkg.sv
// hmbs_pkg: constants, codes and derived widths for the heightmap bilinear sampler
// no dependencies; used by heightmap_bilinear_sampler through scoped names
package hmbs_pkg;

  // map geometry and coordinate format
  localparam int MAX_COLUMNS   = 256;
  localparam int MAX_ROWS      = 256;
  localparam int FRACTION_BITS = 8;

  // fixed field widths
  localparam int POS_W    = 16;
  localparam int SAMPLE_W = 8;
  localparam int HEIGHT_W = 7;
  localparam int CFG_W    = 9;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // derived widths
  localparam int INT_W   = POS_W - FRACTION_BITS;
  localparam int CMP_W   = POS_W + 1;
  localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int HCOL_W  = (COL_W > 1) ? COL_W - 1 : 1;
  localparam int HROW_W  = (ROW_W > 1) ? ROW_W - 1 : 1;
  localparam int BANK_AW = HCOL_W + HROW_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int NUM_BANKS  = 4;
  localparam int WEIGHT_W   = FRACTION_BITS + 1;
  localparam int ROWBL_W    = FRACTION_BITS + SAMPLE_W;
  localparam int BLEND_W    = 2 * FRACTION_BITS + SAMPLE_W;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [0:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } reg_idx_t;

endpackage

FILE: rtl/heightmap_bilinear_sampler.sv
// heightmap_bilinear_sampler: banked heightmap store with a bilinear query pipeline
// depends on hmbs_pkg (constants, opcode and register codes)

// The block holds a MAX_COLUMNS by MAX_ROWS map of 8-bit heights in four
// single-port synchronous banks, split by row and column parity, so the four
// corners of any cell sit in four different banks and are read in the same cycle.
// A load writes one sample (loads outside map_width/map_height are dropped and
// give no result); a query with Q8.8 coordinates returns the bilinear blend,
// halved and truncated, or 0 with out_of_range set when the cell leaves the
// map. One item is taken every cycle while in_stall is low; a query result
// passes the bank read, row blend along x and blend along y to the output
// register, and the rate is set by the banks, each serving one read or one
// write per cycle. in_stall rises only while the output register holds a
// stalled result. The store has no reset: reading a sample never loaded gives
// an arbitrary height. The user writes map_width and map_height through the APB
// port at byte addresses 0 and 4 while the block is idle; the block does not enforce this.
module heightmap_bilinear_sampler (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_opcode,
  input  logic [hmbs_pkg::POS_W-1:0]         in_x_pos,
  input  logic [hmbs_pkg::POS_W-1:0]         in_y_pos,
  input  logic [hmbs_pkg::SAMPLE_W-1:0]      in_sample,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hmbs_pkg::HEIGHT_W-1:0]      out_height,
  output logic                               out_out_of_range,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hmbs_pkg::ADDR_W-1:0]        paddr,
  input  logic [hmbs_pkg::DATA_W-1:0]        pwdata,
  output logic [hmbs_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [hmbs_pkg::CFG_W-1:0] map_width_r, map_width_nxt;
  logic [hmbs_pkg::CFG_W-1:0] map_height_r, map_height_nxt;
  logic                       cfg_wr;
  hmbs_pkg::reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = hmbs_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    map_width_nxt  = map_width_r;
    map_height_nxt = map_height_r;
    prdata         = '0;
    unique case (cfg_idx)
      hmbs_pkg::REG_MAP_WIDTH: begin
        prdata = hmbs_pkg::DATA_W'(map_width_r);
        if (cfg_wr) map_width_nxt = pwdata[hmbs_pkg::CFG_W-1:0];
      end
      hmbs_pkg::REG_MAP_HEIGHT: begin
        prdata = hmbs_pkg::DATA_W'(map_height_r);
        if (cfg_wr) map_height_nxt = pwdata[hmbs_pkg::CFG_W-1:0];
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= hmbs_pkg::CFG_W'(256);
      map_height_r <= hmbs_pkg::CFG_W'(256);
    end else begin
      map_width_r  <= map_width_nxt;
      map_height_r <= map_height_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // handshake and pipeline advance
  // ---------------------------------------------------------------------------
  logic out_valid_r, out_valid_nxt;
  logic adv;
  logic in_xfer;
  logic is_query;

  // whole pipeline moves unless a finished result is held back
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign in_xfer  = in_valid && !in_stall;
  assign is_query = (in_opcode == hmbs_pkg::OP_QUERY);

  // ---------------------------------------------------------------------------
  // coordinate decode and range checks
  // ---------------------------------------------------------------------------
  logic [hmbs_pkg::CMP_W-1:0]         col_ext, row_ext, col1_ext, row1_ext;
  logic [hmbs_pkg::CMP_W-1:0]         w_used, h_used;
  logic [hmbs_pkg::COL_W-1:0]         col_lo, col1_lo;
  logic [hmbs_pkg::ROW_W-1:0]         row_lo, row1_lo;
  logic [hmbs_pkg::FRACTION_BITS-1:0] fx, fy;
  logic                               load_ok, query_oor;

  assign col_ext  = hmbs_pkg::CMP_W'(in_x_pos[hmbs_pkg::POS_W-1:hmbs_pkg::FRACTION_BITS]);
  assign row_ext  = hmbs_pkg::CMP_W'(in_y_pos[hmbs_pkg::POS_W-1:hmbs_pkg::FRACTION_BITS]);
  assign col1_ext = col_ext + hmbs_pkg::CMP_W'(1);
  assign row1_ext = row_ext + hmbs_pkg::CMP_W'(1);
  assign fx       = in_x_pos[hmbs_pkg::FRACTION_BITS-1:0];
  assign fy       = in_y_pos[hmbs_pkg::FRACTION_BITS-1:0];

  // sizes above the store limit act as the limit
  assign w_used = (hmbs_pkg::CMP_W'(map_width_r) > hmbs_pkg::CMP_W'(hmbs_pkg::MAX_COLUMNS))
                  ? hmbs_pkg::CMP_W'(hmbs_pkg::MAX_COLUMNS) : hmbs_pkg::CMP_W'(map_width_r);
  assign h_used = (hmbs_pkg::CMP_W'(map_height_r) > hmbs_pkg::CMP_W'(hmbs_pkg::MAX_ROWS))
                  ? hmbs_pkg::CMP_W'(hmbs_pkg::MAX_ROWS) : hmbs_pkg::CMP_W'(map_height_r);

  assign load_ok   = (col_ext < w_used) && (row_ext < h_used);
  assign query_oor = (col1_ext >= w_used) || (row1_ext >= h_used);

  assign col_lo  = col_ext[hmbs_pkg::COL_W-1:0];
  assign col1_lo = col1_ext[hmbs_pkg::COL_W-1:0];
  assign row_lo  = row_ext[hmbs_pkg::ROW_W-1:0];
  assign row1_lo = row1_ext[hmbs_pkg::ROW_W-1:0];

  // ---------------------------------------------------------------------------
  // bank addressing: bank {row parity, column parity}, entry {row/2, col/2}
  // ---------------------------------------------------------------------------
  logic [hmbs_pkg::BANK_AW-1:0] bank_addr [hmbs_pkg::NUM_BANKS];
  logic [hmbs_pkg::NUM_BANKS-1:0] bank_we, bank_re;

  always_comb begin
    logic [hmbs_pkg::COL_W-1:0] csel;
    logic [hmbs_pkg::ROW_W-1:0] rsel;
    logic [1:0]                 load_bank;
    load_bank = {row_lo[0], col_lo[0]};
    for (int b = 0; b < hmbs_pkg::NUM_BANKS; b++) begin
      if (is_query) begin
        // pick whichever of col/col+1 and row/row+1 has this bank's parity
        csel = (col_lo[0] == b[0]) ? col_lo : col1_lo;
        rsel = (row_lo[0] == b[1]) ? row_lo : row1_lo;
      end else begin
        csel = col_lo;
        rsel = row_lo;
      end
      bank_addr[b] = {hmbs_pkg::HROW_W'(rsel >> 1), hmbs_pkg::HCOL_W'(csel >> 1)};
      bank_we[b]   = in_xfer && !is_query && load_ok && (load_bank == 2'(b));
      bank_re[b]   = in_xfer && is_query;
    end
  end

  // four single-port banks, registered read data
  logic [hmbs_pkg::SAMPLE_W-1:0] bank_mem [hmbs_pkg::NUM_BANKS][hmbs_pkg::BANK_DEPTH];
  logic [hmbs_pkg::SAMPLE_W-1:0] bank_rd_r [hmbs_pkg::NUM_BANKS];

  always_ff @(posedge clk) begin
    for (int b = 0; b < hmbs_pkg::NUM_BANKS; b++) begin
      if (bank_we[b]) bank_mem[b][bank_addr[b]] <= in_sample;
      if (bank_re[b]) bank_rd_r[b] <= bank_mem[b][bank_addr[b]];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: read data arrives; keep fractions, parities and range flag
  // ---------------------------------------------------------------------------
  logic                               s1_valid_r, s1_valid_nxt;
  logic [hmbs_pkg::FRACTION_BITS-1:0] s1_fx_r, s1_fy_r;
  logic                               s1_oor_r, s1_col0_r, s1_row0_r;

  assign s1_valid_nxt = adv ? (in_xfer && is_query) : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_fx_r   <= fx;
      s1_fy_r   <= fy;
      s1_oor_r  <= query_oor;
      s1_col0_r <= col_lo[0];
      s1_row0_r <= row_lo[0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: blend along x for both rows
  // ---------------------------------------------------------------------------
  logic [hmbs_pkg::SAMPLE_W-1:0]      q11, q21, q12, q22;
  logic [hmbs_pkg::WEIGHT_W-1:0]      omfx;
  logic [hmbs_pkg::ROWBL_W-1:0]       row_a_nxt, row_b_nxt;
  logic                               s2_valid_r, s2_valid_nxt;
  logic [hmbs_pkg::ROWBL_W-1:0]       s2_row_a_r, s2_row_b_r;
  logic [hmbs_pkg::FRACTION_BITS-1:0] s2_fy_r;
  logic                               s2_oor_r;

  assign q11 = bank_rd_r[{s1_row0_r, s1_col0_r}];
  assign q21 = bank_rd_r[{s1_row0_r, ~s1_col0_r}];
  assign q12 = bank_rd_r[{~s1_row0_r, s1_col0_r}];
  assign q22 = bank_rd_r[{~s1_row0_r, ~s1_col0_r}];

  assign omfx = hmbs_pkg::WEIGHT_W'(1 << hmbs_pkg::FRACTION_BITS)
              - hmbs_pkg::WEIGHT_W'(s1_fx_r);

  assign row_a_nxt = hmbs_pkg::ROWBL_W'(omfx) * hmbs_pkg::ROWBL_W'(q11)
                   + hmbs_pkg::ROWBL_W'(s1_fx_r) * hmbs_pkg::ROWBL_W'(q21);
  assign row_b_nxt = hmbs_pkg::ROWBL_W'(omfx) * hmbs_pkg::ROWBL_W'(q12)
                   + hmbs_pkg::ROWBL_W'(s1_fx_r) * hmbs_pkg::ROWBL_W'(q22);

  assign s2_valid_nxt = adv ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_row_a_r <= row_a_nxt;
      s2_row_b_r <= row_b_nxt;
      s2_fy_r    <= s1_fy_r;
      s2_oor_r   <= s1_oor_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: blend along y, halve, truncate into the output register
  // ---------------------------------------------------------------------------
  logic [hmbs_pkg::WEIGHT_W-1:0]  omfy;
  logic [hmbs_pkg::BLEND_W-1:0]   blend;
  logic [hmbs_pkg::HEIGHT_W-1:0]  height_nxt;
  logic [hmbs_pkg::HEIGHT_W-1:0]  out_height_r;
  logic                           out_oor_r;

  assign omfy  = hmbs_pkg::WEIGHT_W'(1 << hmbs_pkg::FRACTION_BITS)
               - hmbs_pkg::WEIGHT_W'(s2_fy_r);
  assign blend = hmbs_pkg::BLEND_W'(omfy) * hmbs_pkg::BLEND_W'(s2_row_a_r)
               + hmbs_pkg::BLEND_W'(s2_fy_r) * hmbs_pkg::BLEND_W'(s2_row_b_r);

  // blend >> (2F+1) keeps exactly the top seven bits
  assign height_nxt = s2_oor_r ? '0
                    : blend[hmbs_pkg::BLEND_W-1 -: hmbs_pkg::HEIGHT_W];

  assign out_valid_nxt = adv ? s2_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_height_r <= height_nxt;
      out_oor_r    <= s2_oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_height       = out_height_r;
  assign out_out_of_range = out_oor_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_oor_r |-> out_height_r == '0)
    else $error("out of range result with nonzero height");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled without a held result");

  a_query_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && is_query |=> s1_valid_r)
    else $error("accepted query lost before stage 1");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !is_query |=> !s1_valid_r)
    else $error("load produced a pipeline item");

  a_bank_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (bank_we & bank_re) == '0 && $countones(bank_we) <= 1)
    else $error("bank written and read in one cycle");

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for heightmap_bilinear_sampler
// depends on hmbs_pkg and the sampler rtl; holds its own bilinear height predictor
// directed corner, size and backpressure tests, then random load and query traffic
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_ONE       = 1 << hmbs_pkg::FRACTION_BITS;
  localparam int MAP_CELLS      = hmbs_pkg::MAX_COLUMNS * hmbs_pkg::MAX_ROWS;
  localparam int PIPE_DRAIN     = 8;     // covers the result pipeline, keep some margin
  localparam int WATCHDOG_LIMIT = 2000;  // longest legal quiet stretch is the long hold-off
  localparam int HOLD_OFF       = 150;
  localparam int PHASE_ITEMS    = 200;

  // one result transfer as the predictor sees it
  typedef struct packed {
    logic [hmbs_pkg::HEIGHT_W-1:0] height;
    logic                          out_of_range;
  } height_result_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_opcode;
  logic [hmbs_pkg::POS_W-1:0]    in_x_pos;
  logic [hmbs_pkg::POS_W-1:0]    in_y_pos;
  logic [hmbs_pkg::SAMPLE_W-1:0] in_sample;
  logic                          out_valid;
  logic                          out_stall;
  logic [hmbs_pkg::HEIGHT_W-1:0] out_height;
  logic                          out_out_of_range;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [hmbs_pkg::ADDR_W-1:0]   paddr;
  logic [hmbs_pkg::DATA_W-1:0]   pwdata;
  logic [hmbs_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  // predictor state: map contents, which entries were ever loaded, size registers
  bit   [hmbs_pkg::SAMPLE_W-1:0] height_mem [MAP_CELLS];
  bit                            loaded_mask [MAP_CELLS];
  logic [hmbs_pkg::CFG_W-1:0]    map_cols;
  logic [hmbs_pkg::CFG_W-1:0]    map_rows;

  height_result_t      expected_heights [$];
  height_result_t      want;

  int unsigned         failures;
  int unsigned         kept_items;     // queries plus loads that land inside the map
  int unsigned         results_checked;
  int unsigned         oor_checked;
  int unsigned         size_settings;
  int unsigned         quiet_cycles;
  int unsigned         input_stall_cycles;
  int unsigned         hold_cycles;
  bit                  send_quiet;
  bit                  recv_quiet;

  heightmap_bilinear_sampler dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_x_pos         (in_x_pos),
    .in_y_pos         (in_y_pos),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_height       (out_height),
    .out_out_of_range (out_out_of_range),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // sizes above the store dimensions behave as the full store
  function automatic int unsigned eff_cols();
    return (map_cols > hmbs_pkg::MAX_COLUMNS) ? hmbs_pkg::MAX_COLUMNS : map_cols;
  endfunction

  function automatic int unsigned eff_rows();
    return (map_rows > hmbs_pkg::MAX_ROWS) ? hmbs_pkg::MAX_ROWS : map_rows;
  endfunction

  function automatic int unsigned cell_index(input int unsigned col, input int unsigned row);
    return col + row * hmbs_pkg::MAX_COLUMNS;
  endfunction

  // the whole 2x2 cell, right and lower neighbours included, must sit inside the map
  function automatic bit cell_inside(input int unsigned col, input int unsigned row);
    return (col + 1 < eff_cols()) && (row + 1 < eff_rows());
  endfunction

  // integer part given, fraction drawn at random
  function automatic logic [hmbs_pkg::POS_W-1:0] fixed_pos(input int unsigned whole);
    return hmbs_pkg::POS_W'((whole << hmbs_pkg::FRACTION_BITS)
                            | $urandom_range(0, FRAC_ONE - 1));
  endfunction

  // blend along x on both rows, then along y, then halve and truncate
  function automatic height_result_t predict_height(input logic [hmbs_pkg::POS_W-1:0] x,
                                                    input logic [hmbs_pkg::POS_W-1:0] y);
    height_result_t  res;
    int unsigned     col;
    int unsigned     row;
    longint unsigned fx;
    longint unsigned fy;
    longint unsigned upper_row;
    longint unsigned lower_row;
    longint unsigned blend;
    col = 32'(x >> hmbs_pkg::FRACTION_BITS);
    row = 32'(y >> hmbs_pkg::FRACTION_BITS);
    res = '0;
    if (!cell_inside(col, row)) begin
      res.out_of_range = 1'b1;
      return res;
    end
    fx = 64'(x & hmbs_pkg::POS_W'(FRAC_ONE - 1));
    fy = 64'(y & hmbs_pkg::POS_W'(FRAC_ONE - 1));
    upper_row = (FRAC_ONE - fx) * height_mem[cell_index(col, row)]
              + fx * height_mem[cell_index(col + 1, row)];
    lower_row = (FRAC_ONE - fx) * height_mem[cell_index(col, row + 1)]
              + fx * height_mem[cell_index(col + 1, row + 1)];
    blend = (FRAC_ONE - fy) * upper_row + fy * lower_row;
    res.height = hmbs_pkg::HEIGHT_W'(blend >> (2 * hmbs_pkg::FRACTION_BITS + 1));
    return res;
  endfunction

  // update the predictor for one accepted input transfer
  function automatic void apply_item(input hmbs_pkg::opcode_t op,
                                     input logic [hmbs_pkg::POS_W-1:0] x,
                                     input logic [hmbs_pkg::POS_W-1:0] y,
                                     input logic [hmbs_pkg::SAMPLE_W-1:0] s);
    int unsigned col;
    int unsigned row;
    col = 32'(x >> hmbs_pkg::FRACTION_BITS);
    row = 32'(y >> hmbs_pkg::FRACTION_BITS);
    if (op == hmbs_pkg::OP_QUERY) begin
      expected_heights.push_back(predict_height(x, y));
      kept_items++;
    end else if (col < eff_cols() && row < eff_rows()) begin
      // loads outside the map are dropped silently
      height_mem[cell_index(col, row)]  = s;
      loaded_mask[cell_index(col, row)] = 1'b1;
      kept_items++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one input transfer; a zero gap keeps valid high straight into the next item
  task automatic send_item(input hmbs_pkg::opcode_t op,
                           input logic [hmbs_pkg::POS_W-1:0] x,
                           input logic [hmbs_pkg::POS_W-1:0] y,
                           input logic [hmbs_pkg::SAMPLE_W-1:0] s);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_x_pos  <= x;
    in_y_pos  <= y;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    apply_item(op, x, y, s);
  endtask

  task automatic load_sample(input int unsigned col, input int unsigned row,
                             input logic [hmbs_pkg::SAMPLE_W-1:0] s);
    send_item(hmbs_pkg::OP_LOAD, fixed_pos(col), fixed_pos(row), s);
  endtask

  // never read a sample that was not loaded: fill any missing corner first
  task automatic query_point(input logic [hmbs_pkg::POS_W-1:0] x,
                             input logic [hmbs_pkg::POS_W-1:0] y);
    int unsigned col;
    int unsigned row;
    col = 32'(x >> hmbs_pkg::FRACTION_BITS);
    row = 32'(y >> hmbs_pkg::FRACTION_BITS);
    if (cell_inside(col, row)) begin
      for (int dy = 0; dy < 2; dy++) begin
        for (int dx = 0; dx < 2; dx++) begin
          if (!loaded_mask[cell_index(col + dx, row + dy)])
            load_sample(col + dx, row + dy, hmbs_pkg::SAMPLE_W'($urandom));
        end
      end
    end
    // the sample field of a query is ignored, so it carries noise
    send_item(hmbs_pkg::OP_QUERY, x, y, hmbs_pkg::SAMPLE_W'($urandom));
  endtask

  // drop valid, wait for every expected result, then let in-flight loads retire
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_heights.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  // setup phase, access phase, then idle with psel low before the next transfer
  task automatic apb_write(input hmbs_pkg::reg_idx_t idx,
                           input logic [hmbs_pkg::CFG_W-1:0] value);
    logic [hmbs_pkg::DATA_W-1:0] word;
    word = $urandom;
    word[hmbs_pkg::CFG_W-1:0] = value;  // bits above the register width are ignored
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= hmbs_pkg::ADDR_W'(idx) << 2;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == hmbs_pkg::REG_MAP_WIDTH) map_cols = value;
    else map_rows = value;
    @(posedge clk);
  endtask

  task automatic write_map_size(input int unsigned cols, input int unsigned rows);
    wait_drained();
    apb_write(hmbs_pkg::REG_MAP_WIDTH, hmbs_pkg::CFG_W'(cols));
    apb_write(hmbs_pkg::REG_MAP_HEIGHT, hmbs_pkg::CFG_W'(rows));
    size_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // stall drawn per result; a requested hold-off is folded into the same count so
  // out_stall changes at most once per edge
  initial begin : result_receiver
    int unsigned pause;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      pause = (recv_quiet ? 0 : $urandom_range(0, 13)) + hold_cycles;
      hold_cycles = 0;
      if (pause != 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // compare each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_heights.size() == 0) begin
        $display("%0t: result with nothing expected: height %0d out_of_range %0b",
                 $time, out_height, out_out_of_range);
        failures++;
      end else begin
        want = expected_heights.pop_front();
        results_checked++;
        if (want.out_of_range) oor_checked++;
        if (out_height !== want.height) begin
          $display("%0t: height mismatch, expected %0d got %0d",
                   $time, want.height, out_height);
          failures++;
        end
        if (out_out_of_range !== want.out_of_range) begin
          $display("%0t: out_of_range mismatch, expected %0b got %0b",
                   $time, want.out_of_range, out_out_of_range);
          failures++;
        end
      end
    end
  end

  // watchdog: any transfer on either channel resets the quiet count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (in_valid && in_stall) input_stall_cycles <= input_stall_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_heights.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset size 256x256: extreme samples, extreme fractions, the last full cell and
  // cells that leave the map on the right, at the bottom and at both
  task automatic test_corner_cells();
    load_sample(0, 0, 8'h00);
    load_sample(1, 0, 8'hFF);
    load_sample(0, 1, 8'hFF);
    load_sample(1, 1, 8'h00);
    query_point(16'h0000, 16'h0000);
    query_point(16'h00FF, 16'h0000);
    query_point(16'h0080, 16'h0080);
    query_point(16'h00FF, 16'h00FF);
    load_sample(hmbs_pkg::MAX_COLUMNS - 2, hmbs_pkg::MAX_ROWS - 2, 8'hFF);
    load_sample(hmbs_pkg::MAX_COLUMNS - 1, hmbs_pkg::MAX_ROWS - 2, 8'hFF);
    load_sample(hmbs_pkg::MAX_COLUMNS - 2, hmbs_pkg::MAX_ROWS - 1, 8'hFF);
    load_sample(hmbs_pkg::MAX_COLUMNS - 1, hmbs_pkg::MAX_ROWS - 1, 8'hFF);
    query_point(16'hFEFF, 16'hFEFF);  // all-max cell at top fraction gives the top height
    query_point(16'hFF00, 16'h0000);
    query_point(16'h0000, 16'hFF80);
    query_point(16'hFFFF, 16'hFFFF);
  endtask

  // smallest legal map, sizes below two, sizes above the store, then back to full
  task automatic test_map_size_limits();
    write_map_size(2, 2);
    query_point(16'h0040, 16'h00C0);
    query_point(16'h0100, 16'h0000);
    load_sample(2, 0, 8'hA5);         // column past the map: dropped
    load_sample(0, 2, 8'h3C);         // row past the map: dropped
    write_map_size(0, 1);
    query_point(16'h0000, 16'h0000);
    load_sample(0, 0, 8'h77);         // zero width, nothing can land
    write_map_size(1, 1);
    load_sample(0, 0, 8'h5A);         // single-sample map still takes loads
    query_point(16'h0000, 16'h0000);
    write_map_size(511, 300);
    query_point(16'hFE10, 16'hFE20);
    query_point(16'hFF00, 16'h0100);
    write_map_size(hmbs_pkg::MAX_COLUMNS, hmbs_pkg::MAX_ROWS);
  endtask

  // receiver holds off for a long stretch while the sender keeps offering, so the
  // pipeline fills and in_stall has to rise
  task automatic test_backpressure();
    send_quiet  = 1'b1;
    recv_quiet  = 1'b1;
    hold_cycles = HOLD_OFF;
    repeat (40) query_point(fixed_pos($urandom_range(0, 3)), fixed_pos($urandom_range(0, 3)));
    wait_drained();
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  // phases of random traffic under different map sizes; most items are queries on
  // cells inside the map, the rest edge cells, stray loads and raw coordinates
  task automatic test_random_traffic();
    int unsigned phase_start;
    int unsigned kind;
    int unsigned w;
    int unsigned h;
    for (int phase = 0; phase < 5; phase++) begin
      unique case (phase)
        0:       write_map_size($urandom_range(2, 12), $urandom_range(2, 12));
        1:       write_map_size(hmbs_pkg::MAX_COLUMNS, hmbs_pkg::MAX_ROWS);
        2:       write_map_size($urandom_range(2, 256), $urandom_range(2, 256));
        3:       write_map_size($urandom_range(257, 511), $urandom_range(2, 40));
        default: write_map_size($urandom_range(2, 40), $urandom_range(257, 511));
      endcase
      w = eff_cols();
      h = eff_rows();
      phase_start = kept_items;
      while (kept_items - phase_start < PHASE_ITEMS) begin
        // switch idling styles now and then so gap-free stretches occur too
        if ($urandom_range(0, 39) == 0) begin
          send_quiet = ($urandom_range(0, 3) == 0);
          recv_quiet = ($urandom_range(0, 3) == 0);
        end
        kind = $urandom_range(0, 9);
        if (kind < 6)
          query_point(fixed_pos($urandom_range(0, w - 2)), fixed_pos($urandom_range(0, h - 2)));
        else if (kind == 6)
          query_point(fixed_pos(w - 2 + $urandom_range(0, 1)),
                      fixed_pos($urandom_range(0, h - 2)));
        else if (kind == 7)
          query_point(fixed_pos($urandom_range(0, w - 2)),
                      fixed_pos(h - 2 + $urandom_range(0, 1)));
        else if (kind == 8)
          send_item(hmbs_pkg::OP_LOAD, hmbs_pkg::POS_W'($urandom), hmbs_pkg::POS_W'($urandom),
                    hmbs_pkg::SAMPLE_W'($urandom));
        else
          query_point(hmbs_pkg::POS_W'($urandom), hmbs_pkg::POS_W'($urandom));
      end
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_opcode <= hmbs_pkg::OP_LOAD;
    in_x_pos  <= '0;
    in_y_pos  <= '0;
    in_sample <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    map_cols  = hmbs_pkg::CFG_W'(hmbs_pkg::MAX_COLUMNS);
    map_rows  = hmbs_pkg::CFG_W'(hmbs_pkg::MAX_ROWS);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_corner_cells();
    test_map_size_limits();
    test_backpressure();
    test_random_traffic();

    wait_drained();
    $display("checked %0d heights (%0d out of range) from %0d kept items", results_checked,
             oor_checked, kept_items);
    $display("map size settings: %0d, cycles with input held back: %0d, errors: %0d",
             size_settings, input_stall_cycles, failures);
    if (failures == 0 && expected_heights.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
